### design/ova_pkg.sv
// Shared types and constants for the oldest-voice allocator.
// No dependencies; imported by the allocator and its checker.
package ova_pkg;

    localparam int NOTE_W    = 7;
    localparam int ELAPSED_W = 16;
    localparam int VIDX_W    = 3;
    localparam int MASK_W    = 8;

    // event kinds
    localparam logic CMD_NOTE_OFF = 1'b0;
    localparam logic CMD_NOTE_ON  = 1'b1;

    typedef logic [NOTE_W-1:0]    note_t;
    typedef logic [ELAPSED_W-1:0] elapsed_t;
    typedef logic [VIDX_W-1:0]    vidx_t;
    typedef logic [MASK_W-1:0]    mask_t;

endpackage

### design/ova_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ova_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### design/oldest_voice_allocator.sv
// Polyphonic voice allocator with oldest-note stealing; uses ova_pkg and ova_ram.
// Voice state {gate, note, age} lives in one RAM entry per voice.

// Each event (note on / note off plus elapsed ticks) sweeps the voice RAM one
// voice per cycle through its single read port: every age is advanced with
// saturation and written back, note offs release matching gated voices on the
// way, and note ons track the oldest free and oldest busy voice, then write the
// chosen voice in a final commit cycle, which also loads the result into the
// output register and returns to idle, where the next event is accepted. A
// waiting result does not block acceptance; the next event sweeps and then
// holds in its commit cycle until that result is taken. After reset a clearing
// pass zeroes every RAM entry before the first event is accepted.
module oldest_voice_allocator
    import ova_pkg::*;
#(
    parameter int NUM_VOICES = 8,
    parameter int AGE_BITS   = 24
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     cmd,
    input  note_t    note,
    input  elapsed_t elapsed,
    output logic     out_valid,
    input  logic     out_ready,
    output vidx_t    voice_index,
    output logic     assigned,
    output logic     stolen,
    output note_t    stolen_note,
    output mask_t    released_mask
);

    localparam int IDX_W  = $clog2(NUM_VOICES);
    localparam int CNT_W  = $clog2(NUM_VOICES + 1);
    localparam int DATA_W = 1 + NOTE_W + AGE_BITS;
    localparam int SUM_W  = ((AGE_BITS > ELAPSED_W) ? AGE_BITS : ELAPSED_W) + 1;
    localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;
    localparam logic [CNT_W-1:0]    CNT_LAST = CNT_W'(NUM_VOICES);
    localparam logic [CNT_W-1:0]    CNT_CLR  = CNT_W'(NUM_VOICES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_COMMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ev_cmd_reg, ev_cmd_next;
    note_t               ev_note_reg, ev_note_next;
    elapsed_t            ev_elapsed_reg, ev_elapsed_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [AGE_BITS-1:0] free_age_reg, free_age_next;
    logic                busy_found_reg, busy_found_next;
    logic [IDX_W-1:0]    busy_idx_reg, busy_idx_next;
    logic [AGE_BITS-1:0] busy_age_reg, busy_age_next;
    note_t               busy_note_reg, busy_note_next;
    mask_t               rel_reg, rel_next;
    logic                out_valid_reg, out_valid_next;
    vidx_t               voice_index_reg, voice_index_next;
    logic                assigned_reg, assigned_next;
    logic                stolen_reg, stolen_next;
    note_t               stolen_note_reg, stolen_note_next;
    mask_t               released_mask_reg, released_mask_next;

    // RAM port signals
    logic                we;
    logic [IDX_W-1:0]    wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [IDX_W-1:0]    rd_addr;
    logic [DATA_W-1:0]   rd_data;

    // voice being processed in the sweep (read in the previous cycle)
    logic [IDX_W-1:0]    proc_idx;
    logic [31:0]         proc_idx32;
    logic [31:0]         chosen32;
    logic [IDX_W-1:0]    chosen_idx;
    logic                rd_gate;
    note_t               rd_note;
    logic [AGE_BITS-1:0] rd_age;
    logic [SUM_W-1:0]    age_sum;
    logic [AGE_BITS-1:0] aged;
    logic                release_hit;
    logic                out_free;

    ova_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_VOICES)
    ) u_voice_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_gate = rd_data[DATA_W-1];
    assign rd_note = rd_data[AGE_BITS +: NOTE_W];
    assign rd_age  = rd_data[AGE_BITS-1:0];

    assign age_sum = SUM_W'(rd_age) + SUM_W'(ev_elapsed_reg);
    assign aged    = (age_sum > SUM_W'(AGE_MAX)) ? AGE_MAX : age_sum[AGE_BITS-1:0];

    assign proc_idx    = IDX_W'(cnt_reg - CNT_W'(1));
    assign proc_idx32  = 32'(proc_idx);
    assign release_hit = (ev_cmd_reg == CMD_NOTE_OFF) && rd_gate && (rd_note == ev_note_reg);
    assign chosen_idx  = free_found_reg ? free_idx_reg : busy_idx_reg;
    assign chosen32    = 32'(chosen_idx);
    assign out_free    = !out_valid_reg || out_ready;

    assign in_ready = (state_reg == ST_IDLE);
    assign rd_addr  = (cnt_reg < CNT_LAST) ? cnt_reg[IDX_W-1:0] : '0;

    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        ev_cmd_next        = ev_cmd_reg;
        ev_note_next       = ev_note_reg;
        ev_elapsed_next    = ev_elapsed_reg;
        free_found_next    = free_found_reg;
        free_idx_next      = free_idx_reg;
        free_age_next      = free_age_reg;
        busy_found_next    = busy_found_reg;
        busy_idx_next      = busy_idx_reg;
        busy_age_next      = busy_age_reg;
        busy_note_next     = busy_note_reg;
        rel_next           = rel_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        voice_index_next   = voice_index_reg;
        assigned_next      = assigned_reg;
        stolen_next        = stolen_reg;
        stolen_note_next   = stolen_note_reg;
        released_mask_next = released_mask_reg;
        we                 = 1'b0;
        wr_addr            = proc_idx;
        wr_data            = {rd_gate, rd_note, aged};

        unique case (state_reg)
            ST_CLEAR:
            begin
                we      = 1'b1;
                wr_addr = cnt_reg[IDX_W-1:0];
                wr_data = '0;
                if (cnt_reg == CNT_CLR)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ev_cmd_next     = cmd;
                    ev_note_next    = note;
                    ev_elapsed_next = elapsed;
                    free_found_next = 1'b0;
                    busy_found_next = 1'b0;
                    rel_next        = '0;
                    cnt_next        = '0;
                    state_next      = ST_SWEEP;
                end
            end

            ST_SWEEP:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg != '0)
                begin
                    we = 1'b1;
                    if (release_hit)
                    begin
                        wr_data = {1'b0, rd_note, AGE_BITS'(0)};
                        if (proc_idx32 < 32'(MASK_W))
                        begin
                            rel_next[proc_idx32[VIDX_W-1:0]] = 1'b1;
                        end
                    end
                    if (rd_gate)
                    begin
                        if (!busy_found_reg || aged > busy_age_reg)
                        begin
                            busy_found_next = 1'b1;
                            busy_idx_next   = proc_idx;
                            busy_age_next   = aged;
                            busy_note_next  = rd_note;
                        end
                    end
                    else if (!free_found_reg || aged > free_age_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = proc_idx;
                        free_age_next   = aged;
                    end
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end

            ST_COMMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    cnt_next       = '0;
                    if (ev_cmd_reg == CMD_NOTE_ON)
                    begin
                        we                 = 1'b1;
                        wr_addr            = chosen_idx;
                        wr_data            = {1'b1, ev_note_reg, AGE_BITS'(0)};
                        voice_index_next   = chosen32[VIDX_W-1:0];
                        assigned_next      = 1'b1;
                        stolen_next        = !free_found_reg;
                        stolen_note_next   = free_found_reg ? '0 : busy_note_reg;
                        released_mask_next = '0;
                    end
                    else
                    begin
                        voice_index_next   = '0;
                        assigned_next      = 1'b0;
                        stolen_next        = 1'b0;
                        stolen_note_next   = '0;
                        released_mask_next = rel_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            cnt_reg           <= '0;
            ev_cmd_reg        <= CMD_NOTE_OFF;
            ev_note_reg       <= '0;
            ev_elapsed_reg    <= '0;
            free_found_reg    <= 1'b0;
            free_idx_reg      <= '0;
            free_age_reg      <= '0;
            busy_found_reg    <= 1'b0;
            busy_idx_reg      <= '0;
            busy_age_reg      <= '0;
            busy_note_reg     <= '0;
            rel_reg           <= '0;
            out_valid_reg     <= 1'b0;
            voice_index_reg   <= '0;
            assigned_reg      <= 1'b0;
            stolen_reg        <= 1'b0;
            stolen_note_reg   <= '0;
            released_mask_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            ev_cmd_reg        <= ev_cmd_next;
            ev_note_reg       <= ev_note_next;
            ev_elapsed_reg    <= ev_elapsed_next;
            free_found_reg    <= free_found_next;
            free_idx_reg      <= free_idx_next;
            free_age_reg      <= free_age_next;
            busy_found_reg    <= busy_found_next;
            busy_idx_reg      <= busy_idx_next;
            busy_age_reg      <= busy_age_next;
            busy_note_reg     <= busy_note_next;
            rel_reg           <= rel_next;
            out_valid_reg     <= out_valid_next;
            voice_index_reg   <= voice_index_next;
            assigned_reg      <= assigned_next;
            stolen_reg        <= stolen_next;
            stolen_note_reg   <= stolen_note_next;
            released_mask_reg <= released_mask_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign voice_index   = voice_index_reg;
    assign assigned      = assigned_reg;
    assign stolen        = stolen_reg;
    assign stolen_note   = stolen_note_reg;
    assign released_mask = released_mask_reg;

endmodule

### design/ova_checker.sv
// Port-level checker for oldest_voice_allocator, bound to every instance of it.
// Depends on ova_pkg for field types.
module ova_checker
    import ova_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input vidx_t    voice_index,
    input logic     assigned,
    input logic     stolen,
    input note_t    stolen_note,
    input mask_t    released_mask
);

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(voice_index) && $stable(assigned)
            && $stable(stolen) && $stable(stolen_note) && $stable(released_mask))
        else $error("result beat changed while stalled");

    // one event at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second event taken while one is in flight");

    a_on_no_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && assigned |-> released_mask == '0)
        else $error("note on reported released voices");

    a_off_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !assigned |-> voice_index == '0 && !stolen && stolen_note == '0)
        else $error("note off reported an assignment");

    a_steal_note: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stolen |-> stolen_note == '0)
        else $error("stolen note reported without a steal");

endmodule

bind oldest_voice_allocator ova_checker u_ova_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .voice_index   (voice_index),
    .assigned      (assigned),
    .stolen        (stolen),
    .stolen_note   (stolen_note),
    .released_mask (released_mask)
);
